// ===== src/mcch_pkg.sv =====
// shared types, constants and the generator step function for the circle hit counter
// no dependencies; imported by every module of the block
`default_nettype none

package mcch_pkg;

   // xorshift64* generator
   localparam int          SEED_BITS  = 64;
   localparam logic [63:0] SEED_RESET = 64'd11400714819323198484;
   localparam logic [63:0] GEN_MULT   = 64'd2685821657736338717;
   localparam logic [31:0] MULT_LO    = GEN_MULT[31:0];
   localparam logic [31:0] MULT_HI    = GEN_MULT[63:32];
   localparam int          SHIFT_A    = 12;
   localparam int          SHIFT_B    = 25;
   localparam int          SHIFT_C    = 27;

   // fixed-point fractions and their squares
   localparam int FRAC_SHIFT = 11;
   localparam int FRAC_BITS  = 53;
   localparam int SQ_BITS    = 107;

   localparam int HITS_TOTAL_BITS = 40;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // register port
   localparam int   CSR_ADDR_BITS = 4;
   localparam int   CSR_DATA_BITS = 64;
   localparam int   CSR_INDEX_BIT = 3;
   localparam logic REG_IDX_SEED  = 1'b0;

   // one trial as handed from front to back
   typedef struct packed {
      logic [SEED_BITS-1:0] state_x;
      logic [SEED_BITS-1:0] state_y;
      logic                 restart;
      logic                 last_trial;
   } trial_type;

   function automatic logic [SEED_BITS-1:0] xorshift_step(input logic [SEED_BITS-1:0] s);
      logic [SEED_BITS-1:0] t;
      t = s ^ (s >> SHIFT_A);
      t = t ^ (t << SHIFT_B);
      t = t ^ (t >> SHIFT_C);
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== src/mcch_queue.sv =====
// short first-in first-out queue of trials between front and back
// depends on mcch_pkg
`default_nettype none

module mcch_queue import mcch_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire trial_type push_item,
   output logic           full,
   input  wire logic      pop,
   output trial_type      pop_item,
   output logic           empty
);

   trial_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      push_ok, pop_ok;

   assign full     = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/mcch_front.sv =====
// front end: takes trial beats, runs the generator two steps per beat, queues the states
// depends on mcch_pkg
`default_nettype none

module mcch_front import mcch_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic                 req_restart,
   input  wire logic                 req_last_trial,
   input  wire logic [SEED_BITS-1:0] seed,
   input  wire logic                 q_full,
   output logic                      q_push,
   output trial_type                 q_item
);

   logic [SEED_BITS-1:0] gen_ff, gen_in;
   logic [SEED_BITS-1:0] base, state_x, state_y;
   logic                 accept;

   assign accept  = req_push && !q_full;
   // restart reloads from the seed before this trial
   assign base    = req_restart ? seed : gen_ff;
   assign state_x = xorshift_step(base);
   assign state_y = xorshift_step(state_x);
   assign gen_in  = accept ? state_y : gen_ff;

   assign q_push            = accept;
   assign q_item.state_x    = state_x;
   assign q_item.state_y    = state_y;
   assign q_item.restart    = req_restart;
   assign q_item.last_trial = req_last_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= SEED_RESET;
      end else begin
         gen_ff <= gen_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mcch_back.sv =====
// back end: scrambles, squares and sums over one shared 32x32 multiplier, counts hits
// depends on mcch_pkg
`default_nettype none

module mcch_back import mcch_pkg::*; #(
   parameter int HIT_COUNT_BITS = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   input  wire trial_type                  q_item,
   output logic                            q_pop,
   input  wire logic                       rsp_pop,
   output logic                            rsp_empty,
   output logic                            rsp_hit,
   output logic [HITS_TOTAL_BITS-1:0]      rsp_hits_total,
   output logic                            rsp_run_done
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   // what to do with the registered product in the following cycle
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_R_SET,
      ACC_R_HI,
      ACC_SQ_0,
      ACC_SQ_33,
      ACC_SQ_64
   } acc_type;

   localparam int STEP_BITS = 4;

   // sub-steps of one coordinate
   localparam logic [2:0] SUB_LO_LO   = 3'd0;
   localparam logic [2:0] SUB_LO_HI   = 3'd1;
   localparam logic [2:0] SUB_HI_LO   = 3'd2;
   localparam logic [2:0] SUB_WAIT_R  = 3'd3;
   localparam logic [2:0] SUB_SQ_LL   = 3'd4;
   localparam logic [2:0] SUB_SQ_LH   = 3'd5;
   localparam logic [2:0] SUB_SQ_HH   = 3'd6;
   localparam logic [2:0] SUB_WAIT_SQ = 3'd7;

   back_state_type            state_ff, state_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   trial_type                 job_ff, job_in;
   logic [63:0]               r_ff, r_in;
   logic [63:0]               prod_ff, prod_in;
   acc_type                   tag_ff, tag_in, acc_tag;
   logic [SQ_BITS-1:0]        sq_ff, sq_in;
   logic [HIT_COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_base, cnt_next;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_hit_ff;
   logic [HITS_TOTAL_BITS-1:0] out_total_ff, total_in;
   logic                      out_done_ff;

   logic [2:0]           sub;
   logic [63:0]          cur_s;
   logic [FRAC_BITS-1:0] frac;
   logic [31:0]          frac_lo, frac_hi;
   logic [31:0]          mul_a, mul_b;
   logic                 hit, out_free, finish, take_job;

   assign sub     = step_ff[2:0];
   assign cur_s   = step_ff[STEP_BITS-1] ? job_ff.state_y : job_ff.state_x;
   assign frac    = r_ff[63:FRAC_SHIFT];
   assign frac_lo = frac[31:0];
   assign frac_hi = 32'(frac[FRAC_BITS-1:32]);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      acc_tag = ACC_NONE;
      unique case (sub)
         SUB_LO_LO: begin
            mul_a   = cur_s[31:0];
            mul_b   = MULT_LO;
            acc_tag = ACC_R_SET;
         end
         SUB_LO_HI: begin
            mul_a   = cur_s[31:0];
            mul_b   = MULT_HI;
            acc_tag = ACC_R_HI;
         end
         SUB_HI_LO: begin
            mul_a   = cur_s[63:32];
            mul_b   = MULT_LO;
            acc_tag = ACC_R_HI;
         end
         SUB_SQ_LL: begin
            mul_a   = frac_lo;
            mul_b   = frac_lo;
            acc_tag = ACC_SQ_0;
         end
         SUB_SQ_LH: begin
            mul_a   = frac_lo;
            mul_b   = frac_hi;
            acc_tag = ACC_SQ_33;
         end
         SUB_SQ_HH: begin
            mul_a   = frac_hi;
            mul_b   = frac_hi;
            acc_tag = ACC_SQ_64;
         end
         SUB_WAIT_R, SUB_WAIT_SQ: begin
            acc_tag = ACC_NONE;
         end
         default: begin
            acc_tag = ACC_NONE;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign tag_in  = (state_ff == ST_RUN) ? acc_tag : ACC_NONE;

   // result of the trial
   assign hit      = !sq_ff[SQ_BITS-1] || (sq_ff[SQ_BITS-2:0] == '0);
   assign cnt_base = job_ff.restart ? '0 : cnt_ff;
   assign cnt_next = (hit && (cnt_base != '1)) ? cnt_base + 1'b1 : cnt_base;

   generate
      if (HIT_COUNT_BITS > HITS_TOTAL_BITS) begin : g_total_sat
         assign total_in = (|cnt_next[HIT_COUNT_BITS-1:HITS_TOTAL_BITS]) ? '1
                                                    : cnt_next[HITS_TOTAL_BITS-1:0];
      end else if (HIT_COUNT_BITS == HITS_TOTAL_BITS) begin : g_total_eq
         assign total_in = cnt_next;
      end else begin : g_total_ext
         assign total_in = {{(HITS_TOTAL_BITS-HIT_COUNT_BITS){1'b0}}, cnt_next};
      end
   endgenerate

   assign out_free = !out_valid_ff || rsp_pop;
   assign finish   = (state_ff == ST_DONE) && out_free;
   assign take_job = !q_empty && ((state_ff == ST_IDLE) || finish);
   assign q_pop    = take_job;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_job) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = take_job ? ST_RUN : ST_IDLE;
               step_in  = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // deferred accumulation of the previous product
   always_comb begin
      r_in  = r_ff;
      sq_in = sq_ff;
      unique case (tag_ff)
         ACC_R_SET: r_in  = prod_ff;
         ACC_R_HI:  r_in  = r_ff + {prod_ff[31:0], 32'b0};
         ACC_SQ_0:  sq_in = sq_ff + SQ_BITS'(prod_ff);
         ACC_SQ_33: sq_in = sq_ff + (SQ_BITS'(prod_ff) << 33);
         ACC_SQ_64: sq_in = sq_ff + (SQ_BITS'(prod_ff) << 64);
         ACC_NONE:  sq_in = sq_ff;
         default:   sq_in = sq_ff;
      endcase
      if (take_job) begin
         sq_in = '0;
      end
   end

   assign job_in       = take_job ? q_item : job_ff;
   assign cnt_in       = finish ? cnt_next : cnt_ff;
   assign out_valid_in = finish ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         tag_ff       <= ACC_NONE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         tag_ff       <= tag_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      r_ff    <= r_in;
      sq_ff   <= sq_in;
      prod_ff <= prod_in;
      if (finish) begin
         out_hit_ff   <= hit;
         out_total_ff <= total_in;
         out_done_ff  <= job_ff.last_trial;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_hits_total = out_total_ff;
   assign rsp_run_done   = out_done_ff;

endmodule

`default_nettype wire

// ===== src/monte_carlo_circle_hit_counter_core.sv =====
// top level of the quarter-circle hit counter: register port, front, queue and back
// depends on mcch_pkg, mcch_front, mcch_queue and mcch_back
//
// usage
//  - request channel: each beat is one trial (req_restart, req_last_trial), taken on an
//    edge with req_push high and req_full low
//  - response channel: one result beat per trial, in order (rsp_hit, rsp_hits_total,
//    rsp_run_done), valid while rsp_empty is low, taken on an edge with rsp_pop high
//  - register port: the seed lives at byte address 0, written in the access cycle,
//    readable on csr_prdata; pready is tied high
//  - a restart trial reloads the generator from the seed and clears the hit count
// timing
//  - the front runs both generator steps of a trial in its accept cycle
//  - the back does twelve 32x32 partial products on one shared multiplier, plus four
//    drain steps, then compares and counts
//  - the back finishes one trial before it takes the next; the shared multiplier sets the pace
//  - from an idle block a request beat goes through the queue, the back and the result register
// reset: synchronous; seed and generator return to the default seed, count to zero,
//    queue and result register empty
// stalls: a two-entry queue keeps the front taking beats while the back works; a result
//    that is not popped holds the back, and once the queue fills req_full rises
`default_nettype none

module monte_carlo_circle_hit_counter_core import mcch_pkg::*; #(
   parameter int HIT_COUNT_BITS = 40
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic                       req_restart,
   input  wire logic                       req_last_trial,
   // response channel
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic                            rsp_hit,
   output logic [HITS_TOTAL_BITS-1:0]      rsp_hits_total,
   output logic                            rsp_run_done,
   // register port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                            csr_pready
);

   logic [SEED_BITS-1:0] seed_ff, seed_in;
   logic                 csr_write, seed_sel;

   logic      q_push, q_full, q_pop, q_empty;
   trial_type q_push_item, q_pop_item;

   // register port: one 64-bit register, eight-byte stride
   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[CSR_INDEX_BIT] == REG_IDX_SEED);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_in    = (csr_write && seed_sel) ? csr_pwdata : seed_ff;
   assign csr_prdata = seed_sel ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // front: generator and request beat acceptance
   mcch_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_restart    (req_restart),
      .req_last_trial (req_last_trial),
      .seed           (seed_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_push_item)
   );

   assign req_full = q_full;

   // decoupling queue
   mcch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   // back: multiply sequence, compare and count, result register
   mcch_back #(
      .HIT_COUNT_BITS (HIT_COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (q_pop_item),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_hit        (rsp_hit),
      .rsp_hits_total (rsp_hits_total),
      .rsp_run_done   (rsp_run_done)
   );

endmodule

`default_nettype wire

// ===== src/mcch_checker.sv =====
// port-level checks for the circle hit counter, bound to the top level
// depends on mcch_pkg and monte_carlo_circle_hit_counter_core
`default_nettype none

module mcch_checker import mcch_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_full,
   input wire logic                       rsp_empty,
   input wire logic                       rsp_pop,
   input wire logic                       rsp_hit,
   input wire logic [HITS_TOTAL_BITS-1:0] rsp_hits_total,
   input wire logic                       rsp_run_done,
   input wire logic                       csr_psel,
   input wire logic                       csr_penable,
   input wire logic                       csr_pwrite,
   input wire logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input wire logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   input wire logic [CSR_DATA_BITS-1:0]   csr_prdata,
   input wire logic                       csr_pready
);

   // nothing is in flight straight after reset
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result or full flag left over after reset");

   // a hit always leaves a non-zero running count
   a_hit_counts : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_hit) |-> (rsp_hits_total != '0))
      else $error("hit beat with zero running count");

   // a waiting result beat holds until popped
   a_rsp_holds : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_hit) && $stable(rsp_hits_total) && $stable(rsp_run_done)))
      else $error("result beat changed while stalled");

   // seed written is read back
   a_seed_readback : assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
         && (csr_paddr[CSR_INDEX_BIT] == REG_IDX_SEED))
      |=> ((csr_paddr[CSR_INDEX_BIT] != REG_IDX_SEED) || (csr_prdata == $past(csr_pwdata))))
      else $error("seed register readback mismatch");

endmodule

bind monte_carlo_circle_hit_counter_core mcch_checker u_mcch_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// self-checking bench for the quarter-circle hit counter core, driven through its queue-style ports
// depends on mcch_pkg (port widths, register index) and monte_carlo_circle_hit_counter_core
// carries its own xorshift64* trial predictor inside a small scoreboard class

module tb import mcch_pkg::*; ();

   // generator constants, kept local so the predictor stands on its own
   localparam logic [63:0] DEFAULT_SEED  = 64'd11400714819323198484;
   localparam logic [63:0] SCRAMBLE_MULT = 64'd2685821657736338717;
   localparam int          COUNT_BITS    = 40;
   localparam logic [CSR_ADDR_BITS-1:0] SEED_ADDR =
      CSR_ADDR_BITS'(REG_IDX_SEED) << CSR_INDEX_BIT;

   localparam int RAND_PHASES = 9;
   localparam int PHASE_ITEMS = 143;
   localparam int LONG_HOLD   = 200;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                       hit;
      logic [HITS_TOTAL_BITS-1:0] total;
      logic                       done;
   } hit_result_type;

   // predicts each trial on the accepted request beat and holds the results still owed
   class hit_scoreboard_type;
      logic [63:0]           seed_reg  = DEFAULT_SEED;
      logic [63:0]           gen_state = DEFAULT_SEED;
      logic [COUNT_BITS-1:0] hit_count = '0;
      hit_result_type        pending_results[$];
      int                    errors    = 0;

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      // one xorshift step, then the scrambled product's top 53 bits
      function logic [52:0] next_fraction();
         logic [63:0] s;
         logic [63:0] prod;
         s = gen_state;
         s = s ^ (s >> 12);
         s = s ^ (s << 25);
         s = s ^ (s >> 27);
         gen_state = s;
         prod = s * SCRAMBLE_MULT;
         return prod[63:11];
      endfunction

      function void note_trial(logic restart, logic last_trial);
         logic [52:0]    fx;
         logic [52:0]    fy;
         logic [106:0]   radius_sq;
         hit_result_type res;
         if (restart) begin
            gen_state = seed_reg;
            hit_count = '0;
         end
         fx = next_fraction();
         fy = next_fraction();
         // exact compare against 2^106, no rounding
         radius_sq = {54'd0, fx} * {54'd0, fx} + {54'd0, fy} * {54'd0, fy};
         res.hit = (radius_sq <= {1'b1, 106'd0});
         if (res.hit && hit_count != '1)
            hit_count++;
         res.total = hit_count;
         res.done  = last_trial;
         pending_results.push_back(res);
      endfunction

      task check_result(logic hit, logic [HITS_TOTAL_BITS-1:0] total, logic done);
         hit_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result beat with nothing owed: hit %0b total %0d", hit, total));
            return;
         end
         want = pending_results.pop_front();
         if (hit !== want.hit)
            report($sformatf("hit %0b, predicted %0b", hit, want.hit));
         if (total !== want.total)
            report($sformatf("hits_total %0d, predicted %0d", total, want.total));
         if (done !== want.done)
            report($sformatf("run_done %0b, predicted %0b", done, want.done));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic req_push       = 1'b0;
   logic req_restart    = 1'b0;
   logic req_last_trial = 1'b0;
   logic req_full;

   // response side
   logic                       rsp_pop = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_hit;
   logic [HITS_TOTAL_BITS-1:0] rsp_hits_total;
   logic                       rsp_run_done;

   // register port
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // run control shared between the sender and the receiver
   bit calm          = 1'b0;
   bit long_hold_ask = 1'b0;
   int cycle_count   = 0;

   hit_scoreboard_type sb = new;

   monte_carlo_circle_hit_counter_core #(.HIT_COUNT_BITS(COUNT_BITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_restart    (req_restart),
      .req_last_trial (req_last_trial),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hit        (rsp_hit),
      .rsp_hits_total (rsp_hits_total),
      .rsp_run_done   (rsp_run_done),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog: a hung handshake ends the run as a failure
   initial begin : watchdog
      wait (cycle_count > CYCLE_LIMIT);
      $display("tb NOT OK");
      $finish;
   end

   // both channels seen at the rising edge, before the block's own updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            sb.note_trial(req_restart, req_last_trial);
         if (rsp_pop && !rsp_empty)
            sb.check_result(rsp_hit, rsp_hits_total, rsp_run_done);
      end
   end

   // receiver: pops by default, short stall bursts, one long hold when asked
   initial begin : receiver
      @(negedge clock);
      forever begin
         if (long_hold_ask) begin
            // long hold so the queue fills and req_full has to rise
            long_hold_ask = 1'b0;
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // one request beat, maybe after a short gap; returns on the falling edge after acceptance
   task automatic send_trial(input logic restart, input logic last_trial);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_push       <= 1'b1;
      req_restart    <= restart;
      req_last_trial <= last_trial;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // setup then access cycle, then the port goes idle before the task returns
   task automatic csr_access(input logic write, input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic read_seed_check(input logic [63:0] want);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== want)
         sb.report($sformatf("seed reads %0h, written %0h", rd, want));
   endtask

   // only called with the block idle
   task automatic write_seed(input logic [63:0] value);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, value, rd);
      sb.seed_reg = value;
      read_seed_check(value);
   endtask

   task automatic wait_drained;
      while (sb.pending_results.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [63:0] seed_val;
      int          run_len;
      int          sent;
      bit          broken;
      logic        rs;
      logic        lt;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register holds the default seed out of reset
      read_seed_check(DEFAULT_SEED);

      // default seed: first trial runs straight from reset, then restarts and run ends
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b1);
      send_trial(1'b1, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b1, 1'b1);
      send_trial(1'b0, 1'b0);
      req_push <= 1'b0;
      wait_drained;

      // zero seed: generator untouched until the restart, then stuck at zero, all hits
      write_seed(64'd0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b1, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b1);
      req_push <= 1'b0;
      wait_drained;

      // top and bottom of the seed range
      write_seed('1);
      send_trial(1'b1, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b1);
      req_push <= 1'b0;
      wait_drained;
      write_seed(64'd1);
      send_trial(1'b1, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b0);
      send_trial(1'b0, 1'b1);
      req_push <= 1'b0;

      // random phases, each with a fresh seed; mostly well-formed runs
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_drained;
         calm = (ph == RAND_PHASES - 1);
         if (ph == 4)
            seed_val = '1;
         else if (ph == 7)
            seed_val = 64'd1;
         else if (ph == 5)
            seed_val = DEFAULT_SEED;
         else
            seed_val = {$urandom, $urandom};
         if (seed_val == 64'd0)
            seed_val = 64'd1;
         write_seed(seed_val);
         if (ph == 2)
            long_hold_ask = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 12);
            broken  = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < run_len; k++) begin
               rs = (k == 0);
               lt = (k == run_len - 1);
               // noise beats and broken runs: flags at random
               if (broken || $urandom_range(0, 19) == 0) begin
                  rs = 1'($urandom);
                  lt = 1'($urandom);
               end
               send_trial(rs, lt);
               sent++;
               if (ph == 1 && sent == PHASE_ITEMS / 2) begin
                  // sender steps back until every owed result beat has come
                  req_push <= 1'b0;
                  wait_drained;
               end
            end
         end
         req_push <= 1'b0;
      end

      wait_drained;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
